// ===== rtl/mm_pkg.sv =====
package mm_pkg;

  // Shape registers are 4 bits; row and column indices are 3 bits.
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int IDX_W     = 3;
  localparam int CNT_W     = 8;
  // Address width of the largest store (8 x 8 elements).
  localparam int ST_AW     = 6;

  localparam logic [CFG_IDX_W-1:0] REG_A_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 2'd3;

  localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

  // Controller to datapath.
  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic [ST_AW-1:0] wr_addr;
    logic             issue;
    logic [ST_AW-1:0] rd_a_addr;
    logic [ST_AW-1:0] rd_b_addr;
    logic             first;
    logic             last_k;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last_elem;
    logic             err_push;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic stall;
    logic busy;
    logic out_free;
  } status_t;

  // Tag that rides along the multiply-accumulate pipe.
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last_k;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last_elem;
  } tag_t;

endpackage

// ===== rtl/mm_ram.sv =====
module mm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/mm_ctrl.sv =====
module mm_ctrl #(
  parameter int MAX_DIM = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mm_pkg::CFG_W-1:0]      cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  output mm_pkg::cmd_t                  cmd,
  input  mm_pkg::status_t               status
);

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_ERR   = 2'd3;

  localparam int AW = mm_pkg::ST_AW;
  localparam int IW = mm_pkg::IDX_W;
  localparam int CW = mm_pkg::CFG_W;
  localparam int NW = mm_pkg::CNT_W;

  function automatic logic [CW-1:0] clamp_dim(input logic [CW-1:0] v);
    logic [CW-1:0] r;
    if (v == '0) begin
      r = CW'(1);
    end else if (v > CW'(MAX_DIM)) begin
      r = CW'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] a_rows_r, a_cols_r, b_rows_r, b_cols_r;
  logic [NW-1:0] load_count_r, load_count_nxt;
  logic [IW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [AW-1:0] a_base_r, a_base_nxt, b_ptr_r, b_ptr_nxt;

  logic [CW-1:0] ar, ac, br, bc;
  logic [NW-1:0] asz, total, lc, lc_inc;
  logic          is_a, in_acc, k_end, j_end, i_end;

  always_comb begin
    ar     = clamp_dim(a_rows_r);
    ac     = clamp_dim(a_cols_r);
    br     = clamp_dim(b_rows_r);
    bc     = clamp_dim(b_cols_r);
    asz    = {4'b0, ar} * {4'b0, ac};
    total  = asz + ({4'b0, br} * {4'b0, bc});
    // A count left over from a larger shape restarts the run.
    lc     = (load_count_r >= total) ? '0 : load_count_r;
    lc_inc = lc + NW'(1);
    is_a   = lc < asz;
    k_end  = {1'b0, k_r} == (ac - CW'(1));
    j_end  = {1'b0, j_r} == (bc - CW'(1));
    i_end  = {1'b0, i_r} == (ar - CW'(1));
  end

  assign in_ready = state_r == ST_LOAD;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    state_nxt      = state_r;
    load_count_nxt = load_count_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    k_nxt          = k_r;
    a_base_nxt     = a_base_r;
    b_ptr_nxt      = b_ptr_r;

    cmd            = '0;
    cmd.wr_addr    = is_a ? lc[AW-1:0] : AW'(lc - asz);
    cmd.rd_a_addr  = a_base_r + AW'(k_r);
    cmd.rd_b_addr  = b_ptr_r;
    cmd.first      = k_r == '0;
    cmd.last_k     = k_end;
    cmd.row        = i_r;
    cmd.col        = j_r;
    cmd.last_elem  = i_end && j_end;

    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          cmd.wr_a       = is_a;
          cmd.wr_b       = !is_a;
          load_count_nxt = lc_inc;
          if (lc_inc == total) begin
            load_count_nxt = '0;
            i_nxt          = '0;
            j_nxt          = '0;
            k_nxt          = '0;
            a_base_nxt     = '0;
            b_ptr_nxt      = '0;
            state_nxt      = (ac != br) ? ST_ERR : ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (!status.stall) begin
          cmd.issue = 1'b1;
          if (k_end) begin
            k_nxt = '0;
            if (j_end) begin
              j_nxt      = '0;
              b_ptr_nxt  = '0;
              a_base_nxt = a_base_r + AW'(ac);
              if (i_end) begin
                i_nxt     = '0;
                state_nxt = ST_DRAIN;
              end else begin
                i_nxt = i_r + IW'(1);
              end
            end else begin
              j_nxt     = j_r + IW'(1);
              b_ptr_nxt = AW'(j_r) + AW'(1);
            end
          end else begin
            k_nxt     = k_r + IW'(1);
            b_ptr_nxt = b_ptr_r + AW'(bc);
          end
        end
      end
      ST_DRAIN: begin
        if (!status.busy) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_ERR: begin
        cmd.err_push = 1'b1;
        if (status.out_free) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      a_rows_r     <= mm_pkg::DIM_RESET;
      a_cols_r     <= mm_pkg::DIM_RESET;
      b_rows_r     <= mm_pkg::DIM_RESET;
      b_cols_r     <= mm_pkg::DIM_RESET;
      load_count_r <= '0;
      i_r          <= '0;
      j_r          <= '0;
      k_r          <= '0;
      a_base_r     <= '0;
      b_ptr_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      load_count_r <= load_count_nxt;
      i_r          <= i_nxt;
      j_r          <= j_nxt;
      k_r          <= k_nxt;
      a_base_r     <= a_base_nxt;
      b_ptr_r      <= b_ptr_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          mm_pkg::REG_A_ROWS: a_rows_r <= cfg_data;
          mm_pkg::REG_A_COLS: a_cols_r <= cfg_data;
          mm_pkg::REG_B_ROWS: b_rows_r <= cfg_data;
          mm_pkg::REG_B_COLS: b_cols_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== rtl/mm_datapath.sv =====
module mm_datapath #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mm_pkg::cmd_t                  cmd,
  output mm_pkg::status_t               status,
  input  logic signed [ELEM_WIDTH-1:0]  in_element_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [2*ELEM_WIDTH+3:0] out_product_value,
  output logic [mm_pkg::IDX_W-1:0]      out_row,
  output logic [mm_pkg::IDX_W-1:0]      out_col,
  output logic                          out_last_of_run,
  output logic                          out_shape_error
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW    = ELEM_WIDTH;
  localparam int PW    = 2 * ELEM_WIDTH + 4;

  logic [EW-1:0]          a_rd, b_rd;
  mm_pkg::tag_t           s1_r, s2_r, acc_tag_r;
  logic signed [2*EW-1:0] prod_r;
  logic signed [PW-1:0]   acc_r;
  logic                   acc_done_r;
  logic                   adv, out_free;

  logic                   out_valid_r;
  logic signed [PW-1:0]   out_val_r;
  logic [mm_pkg::IDX_W-1:0] out_row_r, out_col_r;
  logic                   out_last_r, out_err_r;

  mm_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_a_ram (
    .clk   (clk),
    .we    (cmd.wr_a),
    .waddr (cmd.wr_addr[AW-1:0]),
    .wdata (in_element_value),
    .re    (cmd.issue),
    .raddr (cmd.rd_a_addr[AW-1:0]),
    .rdata (a_rd)
  );

  mm_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_b_ram (
    .clk   (clk),
    .we    (cmd.wr_b),
    .waddr (cmd.wr_addr[AW-1:0]),
    .wdata (in_element_value),
    .re    (cmd.issue),
    .raddr (cmd.rd_b_addr[AW-1:0]),
    .rdata (b_rd)
  );

  // Whole pipe freezes while a finished sum waits on a full output register.
  assign out_free = !out_valid_r || out_ready;
  assign adv      = !(acc_done_r && out_valid_r && !out_ready);

  assign status.stall    = !adv;
  assign status.busy     = s1_r.valid || s2_r.valid || acc_done_r;
  assign status.out_free = out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r        <= '0;
      s2_r        <= '0;
      acc_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        s1_r.valid     <= cmd.issue;
        s1_r.first     <= cmd.first;
        s1_r.last_k    <= cmd.last_k;
        s1_r.row       <= cmd.row;
        s1_r.col       <= cmd.col;
        s1_r.last_elem <= cmd.last_elem;
        s2_r           <= s1_r;
        acc_done_r     <= s2_r.valid && s2_r.last_k;
      end
      if (acc_done_r && out_free) begin
        out_valid_r <= 1'b1;
      end else if (cmd.err_push && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= $signed(a_rd) * $signed(b_rd);
      if (s2_r.valid) begin
        acc_r     <= s2_r.first ? PW'(prod_r) : acc_r + PW'(prod_r);
        acc_tag_r <= s2_r;
      end
    end
    if (acc_done_r && out_free) begin
      out_val_r  <= acc_r;
      out_row_r  <= acc_tag_r.row;
      out_col_r  <= acc_tag_r.col;
      out_last_r <= acc_tag_r.last_elem;
      out_err_r  <= 1'b0;
    end else if (cmd.err_push && out_free) begin
      out_val_r  <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
      out_last_r <= 1'b1;
      out_err_r  <= 1'b1;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_product_value = out_val_r;
  assign out_row           = out_row_r;
  assign out_col           = out_col_r;
  assign out_last_of_run   = out_last_r;
  assign out_shape_error   = out_err_r;

endmodule

// ===== rtl/matrix_multiply.sv =====
// Channel  | Direction | Beat contents
// ---------+-----------+------------------------------------------------------
// in_      | in        | in_element_value: Q8.8 element, A row-major then B
// out_     | out       | product_value Q20.16, out_row, out_col, last, error
// cfg_     | in        | cfg_index selects a_rows/a_cols/b_rows/b_cols
//
// Load: one element per cycle, in_ready high whenever the block is loading.
// Compute: one multiply-accumulate per cycle while the pipe is not stalled,
//   through the single read port of each store and the one multiplier; a run
//   then drains the MAC pipe and returns to loading.
// Reset is synchronous; the stores are not cleared and need no clearing pass.
// A stalled result freezes the MAC pipe; nothing is dropped.
module matrix_multiply #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_we,
  input  logic [mm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mm_pkg::CFG_W-1:0]        cfg_data,
  // element input
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [ELEM_WIDTH-1:0]    in_element_value,
  // product output
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [2*ELEM_WIDTH+3:0]  out_product_value,
  output logic [mm_pkg::IDX_W-1:0]        out_row,
  output logic [mm_pkg::IDX_W-1:0]        out_col,
  output logic                            out_last_of_run,
  output logic                            out_shape_error
);

  mm_pkg::cmd_t    cmd;
  mm_pkg::status_t status;

  // Controller: shape registers, load counter, i/j/k sweep and addresses.
  mm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // Datapath: A/B stores, multiplier, accumulator and output register.
  mm_datapath #(.MAX_DIM(MAX_DIM), .ELEM_WIDTH(ELEM_WIDTH)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_element_value  (in_element_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_product_value (out_product_value),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_last_of_run   (out_last_of_run),
    .out_shape_error   (out_shape_error)
  );

endmodule

// ===== rtl/mm_checker.sv =====
module mm_checker #(
  parameter int ELEM_WIDTH = 16
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [2*ELEM_WIDTH+3:0] out_product_value,
  input logic [mm_pkg::IDX_W-1:0]       out_row,
  input logic [mm_pkg::IDX_W-1:0]       out_col,
  input logic                           out_last_of_run,
  input logic                           out_shape_error
);

  // Reset leaves no result beat pending.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat valid right after reset");

  // Error beat is a single, final, all-zero beat.
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_shape_error |->
      out_last_of_run && out_product_value == '0 && out_row == '0 && out_col == '0)
    else $error("malformed shape error beat");

  // No loading while a run of results is still being produced.
  a_no_load_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |-> !in_ready)
    else $error("input accepted during a result run");

  // Stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_product_value)
      && $stable(out_row) && $stable(out_col))
    else $error("result beat changed while stalled");

endmodule

bind matrix_multiply mm_checker #(.ELEM_WIDTH(ELEM_WIDTH)) u_mm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_product_value (out_product_value),
  .out_row           (out_row),
  .out_col           (out_col),
  .out_last_of_run   (out_last_of_run),
  .out_shape_error   (out_shape_error)
);

// ===== sim/matrix_multiply_tb.sv =====
module matrix_multiply_tb;

  localparam int ELEM_W       = 16;
  localparam int PROD_W       = 2*ELEM_W + 4;
  localparam int DIM_MAX      = 8;
  localparam int STORE_DEPTH  = DIM_MAX*DIM_MAX;
  localparam int RAND_ITEMS   = 240;     // random element beats
  localparam int QUIET_AFTER  = 200;     // no idling from here on
  localparam int DRAIN_CYCLES = 12;      // MAC pipe drain plus margin
  localparam int CYCLE_LIMIT  = 300000;
  localparam int MAX_REPORTS  = 40;

  // One product beat as the block should present it.
  typedef struct {
    logic signed [PROD_W-1:0]    value;
    logic [mm_pkg::IDX_W-1:0]    row;
    logic [mm_pkg::IDX_W-1:0]    col;
    logic                        last;
    logic                        err;
  } product_t;

  // Directed table: a row either reprograms the shape or sends one element.
  // A typed row carries the single product that its run ends with. That
  // product always sits at row 0, col 0 with the last flag set.
  typedef enum logic {ROW_SHAPE, ROW_ELEM} row_kind_t;
  typedef struct {
    row_kind_t                   kind;
    logic [mm_pkg::CFG_W-1:0]    a_rows;
    logic [mm_pkg::CFG_W-1:0]    a_cols;
    logic [mm_pkg::CFG_W-1:0]    b_rows;
    logic [mm_pkg::CFG_W-1:0]    b_cols;
    logic signed [ELEM_W-1:0]    value;
    logic                        typed;
    logic signed [PROD_W-1:0]    exp_value;
    logic                        exp_err;
  } dir_row_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [mm_pkg::CFG_IDX_W-1:0] cfg_index = mm_pkg::REG_A_ROWS;
  logic [mm_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic signed [ELEM_W-1:0]     in_element_value = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic signed [PROD_W-1:0]     out_product_value;
  logic [mm_pkg::IDX_W-1:0]     out_row;
  logic [mm_pkg::IDX_W-1:0]     out_col;
  logic                         out_last_of_run;
  logic                         out_shape_error;

  // Predictor state: shape registers as written, mirrors of both stores and
  // the count of elements taken in the current run.
  logic [mm_pkg::CFG_W-1:0] shape_reg [4];
  logic signed [ELEM_W-1:0] a_mirror [STORE_DEPTH];
  logic signed [ELEM_W-1:0] b_mirror [STORE_DEPTH];
  int unsigned              fill_cnt;

  product_t    products_due [$];
  dir_row_t    dir_tab [$];
  product_t    head;
  int          errors = 0;
  int unsigned items_sent = 0;
  int unsigned rand_items = 0;
  int unsigned runs = 0;
  int unsigned err_runs = 0;
  int unsigned products_seen = 0;
  int unsigned cycles = 0;
  int unsigned stall_left = 0;
  bit          calm = 1'b0;      // phase with no idling on either side
  bit          quiet = 1'b0;     // tail of the run, no idling at all

  matrix_multiply #(
    .MAX_DIM    (DIM_MAX),
    .ELEM_WIDTH (ELEM_W)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_element_value  (in_element_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_product_value (out_product_value),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_last_of_run   (out_last_of_run),
    .out_shape_error   (out_shape_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= MAX_REPORTS) $display("%0t mismatch: %s", $time, what);
  endtask

  // A register value of 0 acts as 1; anything above 8 acts as 8.
  function automatic int unsigned eff_dim(logic [mm_pkg::CFG_W-1:0] r);
    if (r == 0) return 1;
    if (r > DIM_MAX) return DIM_MAX;
    return r;
  endfunction

  // Take one element into the mirrors; on the last B element queue the
  // whole product matrix, or a single error beat if the inner dims disagree.
  task automatic predict_products(input logic signed [ELEM_W-1:0] v);
    int unsigned              ar, ac, br, bc, asz, total;
    logic signed [PROD_W-1:0] acc;
    product_t                 p;
    ar    = eff_dim(shape_reg[mm_pkg::REG_A_ROWS]);
    ac    = eff_dim(shape_reg[mm_pkg::REG_A_COLS]);
    br    = eff_dim(shape_reg[mm_pkg::REG_B_ROWS]);
    bc    = eff_dim(shape_reg[mm_pkg::REG_B_COLS]);
    asz   = ar*ac;
    total = asz + br*bc;
    // shape shrank under a partial load: start over at A
    if (fill_cnt >= total) fill_cnt = 0;
    if (fill_cnt < asz) a_mirror[fill_cnt % STORE_DEPTH] = v;
    else b_mirror[(fill_cnt - asz) % STORE_DEPTH] = v;
    fill_cnt++;
    if (fill_cnt < total) return;
    fill_cnt = 0;
    runs++;
    if (ac != br) begin
      p = '{value: '0, row: '0, col: '0, last: 1'b1, err: 1'b1};
      products_due.push_back(p);
      err_runs++;
      return;
    end
    for (int unsigned i = 0; i < ar; i++) begin
      for (int unsigned j = 0; j < bc; j++) begin
        acc = '0;
        // Q8.8 x Q8.8 sign-extended to 36 bits, so the sum is exact
        for (int unsigned k = 0; k < ac; k++)
          acc = acc + a_mirror[i*ac + k] * b_mirror[k*bc + j];
        p.value = acc;
        p.row   = mm_pkg::IDX_W'(i);
        p.col   = mm_pkg::IDX_W'(j);
        p.last  = (i == ar - 1) && (j == bc - 1);
        p.err   = 1'b0;
        products_due.push_back(p);
      end
    end
  endtask

  // Quiesce: input low, every product out, then let the pipe drain.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (products_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_we high; load_shape drops it after the last write.
  task automatic write_reg(input logic [mm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mm_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    shape_reg[idx] = val;
  endtask

  task automatic load_shape(input logic [mm_pkg::CFG_W-1:0] ar, ac, br, bc);
    wait_idle();
    write_reg(mm_pkg::REG_A_ROWS, ar);
    write_reg(mm_pkg::REG_A_COLS, ac);
    write_reg(mm_pkg::REG_B_ROWS, br);
    write_reg(mm_pkg::REG_B_COLS, bc);
    cfg_we <= 1'b0;
  endtask

  // One element beat. An optional idle gap goes first. Valid stays high
  // from one beat to the next when there is no gap.
  task automatic send_elem(input logic signed [ELEM_W-1:0] v);
    if (!calm && !quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_element_value <= v;
    do @(posedge clk); while (!in_ready);
    predict_products(v);
    items_sent++;
  endtask

  // Mostly full-range values, with the corners pulled in often.
  function automatic logic signed [ELEM_W-1:0] rand_elem();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return '0;
      3:       return '1;
      default: return ELEM_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Mostly 1..3; the largest shape now and then, plus the clamped codes.
  function automatic logic [mm_pkg::CFG_W-1:0] rand_dim();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick == 1) return mm_pkg::CFG_W'($urandom_range(9, 15));
    if (pick <= 4) return mm_pkg::CFG_W'(DIM_MAX);
    return mm_pkg::CFG_W'($urandom_range(1, 3));
  endfunction

  function automatic void tab_shape(logic [mm_pkg::CFG_W-1:0] ar, ac, br, bc);
    dir_tab.push_back('{kind: ROW_SHAPE, a_rows: ar, a_cols: ac, b_rows: br, b_cols: bc,
                        value: '0, typed: 1'b0, exp_value: '0, exp_err: 1'b0});
  endfunction

  function automatic void tab_elem(logic signed [ELEM_W-1:0] v, logic typed = 1'b0,
                                   logic signed [PROD_W-1:0] p = '0, logic e = 1'b0);
    dir_tab.push_back('{kind: ROW_ELEM, a_rows: '0, a_cols: '0, b_rows: '0, b_cols: '0,
                        value: v, typed: typed, exp_value: p, exp_err: e});
  endfunction

  // Result side: random stall bursts, none in calm or quiet spans.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!calm && !quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 15);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Product monitor: compare each beat against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (products_due.size() == 0) begin
        report_mismatch($sformatf("unexpected product beat r%0d c%0d", out_row, out_col));
      end else begin
        head = products_due.pop_front();
        products_seen++;
        if (out_product_value !== head.value)
          report_mismatch($sformatf("c[%0d][%0d] value %0d, want %0d",
                                    head.row, head.col, out_product_value, head.value));
        if (out_row !== head.row)
          report_mismatch($sformatf("row %0d, want %0d", out_row, head.row));
        if (out_col !== head.col)
          report_mismatch($sformatf("col %0d, want %0d", out_col, head.col));
        if (out_last_of_run !== head.last)
          report_mismatch($sformatf("c[%0d][%0d] last %b, want %b",
                                    head.row, head.col, out_last_of_run, head.last));
        if (out_shape_error !== head.err)
          report_mismatch($sformatf("c[%0d][%0d] shape error %b, want %b",
                                    head.row, head.col, out_shape_error, head.err));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at cycle %0d, %0d products still due", cycles, products_due.size());
      $display("matrix_multiply_tb failed");
      $finish;
    end
  end

  initial begin
    logic [mm_pkg::CFG_W-1:0] ar, ac, br, bc;
    int unsigned              run_len;
    int unsigned              phase;

    foreach (shape_reg[r]) shape_reg[r] = mm_pkg::DIM_RESET;
    fill_cnt = 0;

    // 1x1 times 1x1: corner products, typed in directly
    tab_shape(4'd1, 4'd1, 4'd1, 4'd1);
    tab_elem(16'sh8000);
    tab_elem(16'sh8000, 1'b1, 36'sh0_4000_0000, 1'b0);
    tab_elem(16'sh7FFF);
    tab_elem(16'sh7FFF, 1'b1, 36'sd1073676289, 1'b0);
    tab_elem(16'sh8000);
    tab_elem(16'sh7FFF, 1'b1, -36'sd1073709056, 1'b0);
    // zero codes act as 1: 1.0 * -1.0
    tab_shape(4'd0, 4'd0, 4'd0, 4'd0);
    tab_elem(16'sh0100);
    tab_elem(16'shFF00, 1'b1, -36'sd65536, 1'b0);
    // 1x2 times 3x1: inner dims disagree, one error beat
    tab_shape(4'd1, 4'd2, 4'd3, 4'd1);
    tab_elem(16'sh5555);
    tab_elem(16'shAAAA);
    tab_elem(16'sh0001);
    tab_elem(16'shFFFF);
    tab_elem(16'sh1234, 1'b1, '0, 1'b1);
    // b_cols 15 clamps to 8: scalar times a row of eight
    tab_shape(4'd0, 4'd1, 4'd1, 4'd15);
    tab_elem(16'sh7FFF);
    tab_elem(16'sh8000);
    tab_elem(16'sh7FFF);
    tab_elem(16'sh0001);
    tab_elem(16'shFFFF);
    tab_elem(16'sh0100);
    tab_elem(16'shC3A5);
    tab_elem(16'sh3C5A);
    tab_elem(16'sh0000);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[n]) begin
      if (dir_tab[n].kind == ROW_SHAPE) begin
        load_shape(dir_tab[n].a_rows, dir_tab[n].a_cols,
                   dir_tab[n].b_rows, dir_tab[n].b_cols);
      end else begin
        send_elem(dir_tab[n].value);
        // typed rows replace the predicted product with the hand value
        if (dir_tab[n].typed) begin
          void'(products_due.pop_back());
          products_due.push_back('{value: dir_tab[n].exp_value, row: '0, col: '0,
                                   last: 1'b1, err: dir_tab[n].exp_err});
        end
      end
    end

    // Random runs. The first two pin the widest output (8x1 by 1x8, 64 beats)
    // and the longest dot product (1x8 by 8x1). After that the shapes are
    // random, with a matched inner dim most of the time.
    phase = 0;
    while (rand_items < RAND_ITEMS) begin
      if (phase == 0) begin
        ar = 4'd8; ac = 4'd1; br = 4'd1; bc = 4'd8;
      end else if (phase == 1) begin
        ar = 4'd1; ac = 4'd8; br = 4'd8; bc = 4'd1;
      end else begin
        ar = rand_dim();
        ac = rand_dim();
        br = ($urandom_range(0, 4) == 0) ? rand_dim() : ac;
        bc = rand_dim();
      end
      calm = ($urandom_range(0, 2) == 0);
      load_shape(ar, ac, br, bc);
      run_len = eff_dim(ar)*eff_dim(ac) + eff_dim(br)*eff_dim(bc);
      repeat (run_len) begin
        send_elem(rand_elem());
        rand_items++;
        quiet = (rand_items >= QUIET_AFTER);
      end
      phase++;
    end

    wait_idle();
    $display("ran %0d elements through %0d runs, %0d of them with mismatched shapes",
             items_sent, runs, err_runs);
    $display("compared %0d product beats, %0d mismatches", products_seen, errors);
    if (errors == 0) begin
      $display("matrix_multiply_tb passed");
    end else begin
      $display("matrix_multiply_tb failed");
    end
    $finish;
  end

endmodule
